// ===== design/char_lcd_text_write_sequencer_top_macros.svh =====
// Assertion macros for the character LCD text write sequencer.
// Used by the modules that carry concurrent checks; expects clk and arst_n in scope.
`ifndef CHAR_LCD_TEXT_WRITE_SEQUENCER_TOP_MACROS_SVH
`define CHAR_LCD_TEXT_WRITE_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define CLTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CLTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/clts_pkg.sv =====
// Shared types, constants and helpers of the character LCD text write sequencer.
// No dependencies.
`timescale 1ns / 1ps
package clts_pkg;

	localparam int COLUMNS    = 16;
	localparam int ROWS       = 4;
	localparam int COL_W      = $clog2(COLUMNS + 1);
	localparam int ROW_W      = 2;
	localparam int FIFO_DEPTH = 2;

	localparam logic [7:0] ADDR_CMD_BIT = 8'h80;
	localparam logic [7:0] BOTTOM_SHIFT = 8'd4;

	typedef enum logic [1:0] {
		REG_BOTTOM_VIEW    = 2'd0,
		REG_COMMAND_PREFIX = 2'd1,
		REG_DATA_PREFIX    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic       bottom_view;
		logic [7:0] command_prefix;
		logic [7:0] data_prefix;
	} cfg_t;

	// one queued character: optional address command plus the data byte
	typedef struct packed {
		logic       send_cmd;
		logic [7:0] addr_byte;
		logic [7:0] char_code;
	} entry_t;

	function automatic logic [7:0] row_base(input logic [ROW_W-1:0] row);
		logic [7:0] b;
		case (row)
			2'd0:    b = 8'h04;
			2'd1:    b = 8'h24;
			2'd2:    b = 8'h44;
			2'd3:    b = 8'h64;
			default: b = 8'h04;
		endcase
		return b;
	endfunction

endpackage

// ===== design/clts_ifs.sv =====
// Channel interfaces: character input, bus write output, register write port.
// Standalone; no package dependency.
`timescale 1ns / 1ps
interface clts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic [3:0] start_column;
	logic [1:0] start_row;
	logic       begins_text;

	modport source(output valid, char_code, start_column, start_row, begins_text,
		input ready);
	modport sink(input valid, char_code, start_column, start_row, begins_text,
		output ready);
endinterface

interface clts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] prefix_byte;
	logic [7:0] payload_byte;
	logic       is_command;
	logic       last_of_run;

	modport source(output valid, prefix_byte, payload_byte, is_command, last_of_run,
		input ready);
	modport sink(input valid, prefix_byte, payload_byte, is_command, last_of_run,
		output ready);
endinterface

interface clts_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/clts_cfg.sv =====
// Configuration register file: bottom view flag and the two control prefixes.
// Depends on clts_pkg and clts_cfg_if.
`timescale 1ns / 1ps
module clts_cfg (
	input  logic           clk,
	input  logic           arst_n,
	clts_cfg_if.sink       cfg,
	output clts_pkg::cfg_t regs
);
	import clts_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bottom_view    <= 1'b1;
			regs_q.command_prefix <= 8'h00;
			regs_q.data_prefix    <= 8'h40;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BOTTOM_VIEW:    regs_q.bottom_view    <= cfg.data[0];
				REG_COMMAND_PREFIX: regs_q.command_prefix <= cfg.data;
				REG_DATA_PREFIX:    regs_q.data_prefix    <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/clts_front.sv =====
// Front end: accepts characters, tracks the cursor, decides on an address command.
// Depends on clts_pkg and clts_in_if; feeds clts_fifo.
`timescale 1ns / 1ps
module clts_front (
	input  logic             clk,
	input  logic             arst_n,
	clts_in_if.sink          char_in,
	input  clts_pkg::cfg_t   regs,
	output logic             push_valid,
	input  logic             push_ready,
	output clts_pkg::entry_t push_data
);
	import clts_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [COL_W-1:0] col_n;
	logic [COL_W-1:0] col_adv;
	logic [ROW_W-1:0] row_n;
	logic [ROW_W-1:0] row_sel;
	logic [COL_W-1:0] col_sel;
	logic             send_cmd;
	logic [7:0]       addr_sum;
	logic             accept;

	assign char_in.ready = push_ready;
	assign push_valid    = char_in.valid;
	assign accept        = char_in.valid && push_ready;

	always_comb begin
		row_sel = ({1'b0, char_in.start_row} < 3'(ROWS)) ? char_in.start_row : '0;
		col_sel = (6'(char_in.start_column) < 6'(COLUMNS)) ?
			COL_W'(char_in.start_column) : '0;
		if (char_in.begins_text) begin
			col_n    = col_sel;
			row_n    = row_sel;
			send_cmd = 1'b1;
		end else if (col_q >= COL_W'(COLUMNS)) begin
			col_n    = '0;
			row_n    = (row_q >= ROW_W'(ROWS - 1)) ? '0 : row_q + 1'b1;
			send_cmd = 1'b1;
		end else begin
			col_n    = col_q;
			row_n    = row_q;
			send_cmd = 1'b0;
		end
		col_adv  = (col_n < COL_W'(COLUMNS)) ? col_n + 1'b1 : col_n;
		addr_sum = row_base(row_n) + 8'(col_n)
			- (regs.bottom_view ? BOTTOM_SHIFT : 8'd0);
		push_data.send_cmd  = send_cmd;
		push_data.addr_byte = addr_sum | ADDR_CMD_BIT;
		push_data.char_code = char_in.char_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_adv;
			row_q <= row_n;
		end
	end

endmodule

// ===== design/clts_fifo.sv =====
// Short queue between the front end and the write sequencer.
// Depends on clts_pkg.
`timescale 1ns / 1ps
module clts_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  clts_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output clts_pkg::entry_t pop_data
);
	import clts_pkg::*;

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	entry_t           mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/clts_back.sv =====
// Write sequencer: expands each queued character into command and data writes.
// Depends on clts_pkg, clts_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "char_lcd_text_write_sequencer_top_macros.svh"
module clts_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  clts_pkg::entry_t pop_data,
	input  clts_pkg::cfg_t   regs,
	clts_out_if.source       wr_out
);
	import clts_pkg::*;

	logic       out_valid_q;
	logic [7:0] prefix_q;
	logic [7:0] payload_q;
	logic       is_cmd_q;
	logic       cmd_done_q;
	logic       load;
	logic       emit_cmd;

	assign load      = !out_valid_q || wr_out.ready;
	assign emit_cmd  = pop_data.send_cmd && !cmd_done_q;
	assign pop_ready = load && !emit_cmd;

	assign wr_out.valid        = out_valid_q;
	assign wr_out.prefix_byte  = prefix_q;
	assign wr_out.payload_byte = payload_q;
	assign wr_out.is_command   = is_cmd_q;
	assign wr_out.last_of_run  = !is_cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cmd_done_q  <= 1'b0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid) begin
				cmd_done_q <= emit_cmd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			is_cmd_q  <= emit_cmd;
			prefix_q  <= emit_cmd ? regs.command_prefix : regs.data_prefix;
			payload_q <= emit_cmd ? pop_data.addr_byte : pop_data.char_code;
		end
	end

	`CLTS_ASSERT_IMP(a_cmd_addr_bit, out_valid_q && is_cmd_q, payload_q[7], "address write lacks set-address bit")
	`CLTS_ASSERT_IMP(a_cmd_done_head, cmd_done_q, pop_valid, "command sent but its character left the queue")
	`CLTS_ASSERT_NXT(a_data_follows, wr_out.valid && wr_out.ready && is_cmd_q, out_valid_q && !is_cmd_q, "data write does not follow its command")

endmodule

// ===== design/char_lcd_text_write_sequencer_top.sv =====
// Top level of the character LCD text write sequencer.
// Depends on clts_pkg, clts_ifs, clts_cfg, clts_front, clts_fifo and clts_back.
`timescale 1ns / 1ps
// A character is accepted every cycle while the two-entry queue has room. Each character
// becomes one data write, or two writes (set-address command, then data) when it begins a
// text or follows a full row. The output register issues one write per cycle unless
// wr_out stalls it; an address command adds one write. The first write passes through
// the queue and then the output register before it reaches wr_out. The user must write
// registers only when no request is in flight; the block itself does not enforce it.
module char_lcd_text_write_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	clts_in_if.sink     char_in,
	clts_out_if.source  wr_out,
	clts_cfg_if.sink    cfg
);
	import clts_pkg::*;

	cfg_t   regs;
	entry_t push_data;
	entry_t pop_data;
	logic   push_valid;
	logic   push_ready;
	logic   pop_valid;
	logic   pop_ready;

	clts_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	clts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.regs       (regs),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	clts_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	clts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.regs      (regs),
		.wr_out    (wr_out)
	);

endmodule
